FILE: rtl/core/sar_pkg.sv
`default_nettype none
package sar_pkg;

   // Fixed field and accumulator widths
   localparam int SampleWidth   = 16;
   localparam int AccWidth      = 40;
   localparam int ResidualWidth = 24;
   localparam int AngleWidth    = 16;
   localparam int AngleMax      = 51472;
   localparam int SampleBitsDef = 16;

   // Shared add/sub unit width and iterative step counts
   localparam int AluWidth      = 65;
   localparam int CordicSteps   = 28;
   localparam int SqrtSteps     = 32;
   localparam int DivIntSteps   = 64;
   localparam int DivSteps      = 94;
   localparam int CordWidth     = 34;
   localparam int ZWidth        = 43;
   localparam int TabWidth      = 42;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC,
      ST_CHECK,
      ST_SQRT_A,
      ST_SQRT_B,
      ST_MUL_DEN,
      ST_DIV,
      ST_MUL_CC,
      ST_SIN_SUB,
      ST_SQRT_S,
      ST_CORD_X,
      ST_CORD_Y,
      ST_FINISH
   } sar_state_type;

   typedef logic [TabWidth-1:0] atan_tab_type [CordicSteps];

   // Truncating long division, evaluated only while building the table
   function automatic logic [63:0] const_div(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(1/5) in Q40 by its alternating series
   function automatic logic [63:0] atan_inv5();
      logic [63:0] term;
      logic [63:0] sum;
      term = const_div(64'd1 << 40, 64'd5);
      sum  = '0;
      for (int k = 0; k < 32; k++) begin
         if (term != 0) begin
            if ((k & 1) == 0) sum = sum + const_div(term, 64'(2 * k + 1));
            else              sum = sum - const_div(term, 64'(2 * k + 1));
            term = const_div(term, 64'd25);
         end
      end
      return sum;
   endfunction

   // atan(1/239) in Q40
   function automatic logic [63:0] atan_inv239();
      logic [63:0] term;
      logic [63:0] sum;
      term = const_div(64'd1 << 40, 64'd239);
      sum  = '0;
      for (int k = 0; k < 32; k++) begin
         if (term != 0) begin
            if ((k & 1) == 0) sum = sum + const_div(term, 64'(2 * k + 1));
            else              sum = sum - const_div(term, 64'(2 * k + 1));
            term = const_div(term, 64'd57121);
         end
      end
      return sum;
   endfunction

   // atan(2^-i) in Q40, i >= 1
   function automatic logic [63:0] atan_pow2(input int i);
      logic [63:0] term;
      logic [63:0] sum;
      term = (64'd1 << 40) >> i;
      sum  = '0;
      for (int k = 0; k < 32; k++) begin
         if (term != 0) begin
            if ((k & 1) == 0) sum = sum + const_div(term, 64'(2 * k + 1));
            else              sum = sum - const_div(term, 64'(2 * k + 1));
            term = term >> (2 * i);
         end
      end
      return sum;
   endfunction

   function automatic atan_tab_type build_atan_tab();
      atan_tab_type tab;
      logic [63:0]  t0;
      logic [63:0]  ti;
      t0     = 4 * atan_inv5() - atan_inv239();
      tab[0] = t0[TabWidth-1:0];
      for (int i = 1; i < CordicSteps; i++) begin
         ti     = atan_pow2(i);
         tab[i] = ti[TabWidth-1:0];
      end
      return tab;
   endfunction

   localparam atan_tab_type AtanTab = build_atan_tab();

endpackage
`default_nettype wire

FILE: rtl/core/sar_addsub.sv
`default_nettype none
// Shared wide adder/subtractor; sum[AluWidth] is the borrow on subtract
module sar_addsub (
   input  wire logic [sar_pkg::AluWidth-1:0] opa,
   input  wire logic [sar_pkg::AluWidth-1:0] opb,
   input  wire logic                         sub,
   output logic      [sar_pkg::AluWidth:0]   sum
);

   logic [sar_pkg::AluWidth:0] opb_x;

   always_comb begin
      opb_x = {1'b0, opb} ^ {(sar_pkg::AluWidth + 1){sub}};
      sum   = {1'b0, opa} + opb_x + {{sar_pkg::AluWidth{1'b0}}, sub};
   end

endmodule
`default_nettype wire

FILE: rtl/core/spectral_angle_residual.sv
`default_nettype none
// Spectral angle and L1 residual of one pixel.
// req channel: one transaction per band; tdata carries the recovered and
// original samples, tlast marks the pixel's final band. Each band is
// captured, then multiply-accumulated; tready is low while it accumulates.
// rsp channel: one transaction per pixel, after the final band. tdata holds
// the angle (Q1.15 radians) and the summed absolute difference; tuser flags
// a spectrum with zero energy (angle then 0).
// After the final band's transaction the sequencer runs two 32-step square
// roots, a 94-step restoring divide, a 32-step square root for the sine and
// 28 CORDIC steps (an x state, then a y state), all on one shared 65-bit
// add/sub unit plus one 32x32 multiplier, then loads the result register.
// With zero energy it goes from the check straight to the finish state. No
// new band is taken until the result is in the output register.
// A stalled rsp receiver holds the result; the block holds its finished
// pixel until the output register frees, then returns to accepting bands.
// Reset clears accumulators, sequencer and the output valid.
module spectral_angle_residual #(
   parameter int SAMPLE_BITS = sar_pkg::SampleBitsDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // recovered_sample[15:0], original_sample[31:16]
   input  wire logic        req_tlast,   // last_band
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,   // angle[15:0], abs_residual[39:16]
   output logic             rsp_tuser    // zero_norm
);

   localparam int SW = sar_pkg::SampleWidth;
   localparam int AW = sar_pkg::AccWidth;
   localparam int RW = sar_pkg::ResidualWidth;
   localparam int LW = sar_pkg::AluWidth;
   localparam int CW = sar_pkg::CordWidth;
   localparam int ZW = sar_pkg::ZWidth;
   localparam logic [SW-1:0] SampleMask = SW'((32'd1 << SAMPLE_BITS) - 1);

   sar_pkg::sar_state_type state_ff, state_in;

   logic [SW-1:0]   a_ff, b_ff;
   logic            last_ff;
   logic [AW-1:0]   dot_ff, ea_ff, eb_ff;
   logic [AW-1:0]   dot_in, ea_in, eb_in;
   logic [RW-1:0]   l1_ff, l1_in;
   logic [63:0]     rem_ff, rem_in;
   logic [63:0]     q_ff, q_in;
   logic [31:0]     ra_ff, ra_in;
   logic [63:0]     prod_ff, prod_in;
   logic [31:0]     mul_a, mul_b;
   logic            mul_en;
   logic [CW-1:0]   x_ff, x_in, y_ff, y_in, xt_ff, xt_in;
   logic [ZW-1:0]   z_ff, z_in;
   logic [6:0]      cnt_ff, cnt_in;
   logic            zero_ff, zero_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [15:0]     rsp_angle_ff, rsp_angle_in;
   logic [RW-1:0]   rsp_l1_ff, rsp_l1_in;
   logic            rsp_zero_ff, rsp_zero_in;

   // Shared unit operands
   logic [LW-1:0]   alu_a, alu_b;
   logic            alu_sub;
   logic [LW:0]     alu_sum;

   // Helpers
   logic [2*SW-1:0] ab_prod, aa_prod, bb_prod;
   logic [AW:0]     dot_sum, ea_sum, eb_sum;
   logic [RW:0]     l1_sum;
   logic [SW-1:0]   diff_ab;
   logic [63:0]     bitv;
   logic [64:0]     rem2;
   logic            nbit;
   logic [63:0]     q_shift;
   logic [CW-1:0]   x_mag, y_mag, xs, ys;
   logic [ZW-1:0]   tab_ext;
   logic [ZW-1:0]   z_rnd;
   logic [17:0]     angle_raw;
   logic [15:0]     angle_val;

   sar_addsub u_alu (
      .opa (alu_a),
      .opb (alu_b),
      .sub (alu_sub),
      .sum (alu_sum)
   );

   // Saturating accumulate, square-root bit, shifts toward zero, angle round and clamp
   always_comb begin
      ab_prod = (2*SW)'(a_ff) * (2*SW)'(b_ff);
      aa_prod = (2*SW)'(a_ff) * (2*SW)'(a_ff);
      bb_prod = (2*SW)'(b_ff) * (2*SW)'(b_ff);
      dot_sum = {1'b0, dot_ff} + {{(AW + 1 - 2 * SW){1'b0}}, ab_prod};
      ea_sum  = {1'b0, ea_ff}  + {{(AW + 1 - 2 * SW){1'b0}}, aa_prod};
      eb_sum  = {1'b0, eb_ff}  + {{(AW + 1 - 2 * SW){1'b0}}, bb_prod};
      diff_ab = (a_ff > b_ff) ? a_ff - b_ff : b_ff - a_ff;
      l1_sum  = {1'b0, l1_ff} + {{(RW + 1 - SW){1'b0}}, diff_ab};
      bitv    = 64'd1 << (6'd62 - {cnt_ff[4:0], 1'b0});
      nbit    = (cnt_ff < 7'(AW)) ? dot_ff[6'(AW - 1) - cnt_ff[5:0]] : 1'b0;
      rem2    = {rem_ff, nbit};
      x_mag   = x_ff[CW-1] ? -x_ff : x_ff;
      y_mag   = y_ff[CW-1] ? -y_ff : y_ff;
      xs      = x_ff[CW-1] ? -(x_mag >> cnt_ff[4:0]) : (x_mag >> cnt_ff[4:0]);
      ys      = y_ff[CW-1] ? -(y_mag >> cnt_ff[4:0]) : (y_mag >> cnt_ff[4:0]);
      tab_ext = {1'b0, sar_pkg::AtanTab[cnt_ff[4:0]]};
      z_rnd   = z_ff + (ZW'(1) << 24);
      angle_raw = z_rnd[42:25];
      if (z_ff[ZW-1])                          angle_val = '0;
      else if (angle_raw > 18'(sar_pkg::AngleMax)) angle_val = 16'(sar_pkg::AngleMax);
      else                                     angle_val = angle_raw[15:0];
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      dot_in       = dot_ff;
      ea_in        = ea_ff;
      eb_in        = eb_ff;
      l1_in        = l1_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      ra_in        = ra_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      xt_in        = xt_ff;
      z_in         = z_ff;
      cnt_in       = cnt_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_angle_in = rsp_angle_ff;
      rsp_l1_in    = rsp_l1_ff;
      rsp_zero_in  = rsp_zero_ff;
      req_tready   = 1'b0;
      alu_a        = '0;
      alu_b        = '0;
      alu_sub      = 1'b1;
      mul_a        = '0;
      mul_b        = '0;
      mul_en       = 1'b0;
      q_shift      = '0;

      case (state_ff)
         sar_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = sar_pkg::ST_ACC;
         end
         sar_pkg::ST_ACC: begin
            dot_in = dot_sum[AW] ? '1 : dot_sum[AW-1:0];
            ea_in  = ea_sum[AW]  ? '1 : ea_sum[AW-1:0];
            eb_in  = eb_sum[AW]  ? '1 : eb_sum[AW-1:0];
            l1_in  = l1_sum[RW]  ? '1 : l1_sum[RW-1:0];
            state_in = last_ff ? sar_pkg::ST_CHECK : sar_pkg::ST_IDLE;
         end
         sar_pkg::ST_CHECK: begin
            cnt_in = '0;
            q_in   = '0;
            rem_in = {ea_ff, 24'd0};
            if (ea_ff == '0 || eb_ff == '0) begin
               zero_in  = 1'b1;
               state_in = sar_pkg::ST_FINISH;
            end else begin
               zero_in  = 1'b0;
               state_in = sar_pkg::ST_SQRT_A;
            end
         end
         sar_pkg::ST_SQRT_A, sar_pkg::ST_SQRT_B, sar_pkg::ST_SQRT_S: begin
            // one bit of the integer square root per cycle
            alu_a = {1'b0, rem_ff};
            alu_b = {1'b0, q_ff | bitv};
            if (!alu_sum[LW]) begin
               rem_in = alu_sum[63:0];
               q_in   = (q_ff >> 1) | bitv;
            end else begin
               q_in   = q_ff >> 1;
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(sar_pkg::SqrtSteps - 1)) begin
               cnt_in = '0;
               case (state_ff)
                  sar_pkg::ST_SQRT_A: begin
                     ra_in    = q_in[31:0];
                     q_in     = '0;
                     rem_in   = {eb_ff, 24'd0};
                     state_in = sar_pkg::ST_SQRT_B;
                  end
                  sar_pkg::ST_SQRT_B: state_in = sar_pkg::ST_MUL_DEN;
                  default: begin
                     y_in     = CW'(q_in[31:0]);
                     z_in     = '0;
                     state_in = sar_pkg::ST_CORD_X;
                  end
               endcase
            end
         end
         sar_pkg::ST_MUL_DEN: begin
            mul_a    = ra_ff;
            mul_b    = q_ff[31:0];
            mul_en   = 1'b1;
            rem_in   = '0;
            q_in     = '0;
            cnt_in   = '0;
            state_in = sar_pkg::ST_DIV;
         end
         sar_pkg::ST_DIV: begin
            // restoring divide: 64 integer quotient bits, then 30 fraction bits
            alu_a = rem2;
            alu_b = {1'b0, prod_ff};
            if (!alu_sum[LW]) rem_in = alu_sum[63:0];
            else              rem_in = rem2[63:0];
            q_shift = {q_ff[62:0], !alu_sum[LW]};
            if (cnt_ff >= 7'(sar_pkg::DivIntSteps) && q_shift > (64'd1 << 31))
               q_shift = 64'd1 << 31;
            q_in   = q_shift;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(sar_pkg::DivSteps - 1)) begin
               x_in     = (q_shift > (64'd1 << 30)) ? (CW'(1) << 30) : CW'(q_shift[30:0]);
               state_in = sar_pkg::ST_MUL_CC;
            end
         end
         sar_pkg::ST_MUL_CC: begin
            mul_a    = x_ff[31:0];
            mul_b    = x_ff[31:0];
            mul_en   = 1'b1;
            state_in = sar_pkg::ST_SIN_SUB;
         end
         sar_pkg::ST_SIN_SUB: begin
            alu_a    = LW'(64'd1 << 60);
            alu_b    = {1'b0, prod_ff};
            rem_in   = alu_sum[63:0];
            q_in     = '0;
            cnt_in   = '0;
            state_in = sar_pkg::ST_SQRT_S;
         end
         sar_pkg::ST_CORD_X: begin
            alu_a    = {{(LW - CW){x_ff[CW-1]}}, x_ff};
            alu_b    = {{(LW - CW){ys[CW-1]}}, ys};
            alu_sub  = y_ff[CW-1];
            xt_in    = alu_sum[CW-1:0];
            state_in = sar_pkg::ST_CORD_Y;
         end
         sar_pkg::ST_CORD_Y: begin
            alu_a   = {{(LW - CW){y_ff[CW-1]}}, y_ff};
            alu_b   = {{(LW - CW){xs[CW-1]}}, xs};
            alu_sub = !y_ff[CW-1];
            y_in    = alu_sum[CW-1:0];
            x_in    = xt_ff;
            z_in    = y_ff[CW-1] ? z_ff - tab_ext : z_ff + tab_ext;
            cnt_in  = cnt_ff + 7'd1;
            if (cnt_ff == 7'(sar_pkg::CordicSteps - 1)) state_in = sar_pkg::ST_FINISH;
            else                                        state_in = sar_pkg::ST_CORD_X;
         end
         sar_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_angle_in = zero_ff ? '0 : angle_val;
               rsp_l1_in    = l1_ff;
               rsp_zero_in  = zero_ff;
               dot_in       = '0;
               ea_in        = '0;
               eb_in        = '0;
               l1_in        = '0;
               state_in     = sar_pkg::ST_IDLE;
            end
         end
         default: state_in = sar_pkg::ST_IDLE;
      endcase
      prod_in = mul_en ? mul_a * mul_b : prod_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sar_pkg::ST_IDLE;
         dot_ff       <= '0;
         ea_ff        <= '0;
         eb_ff        <= '0;
         l1_ff        <= '0;
         cnt_ff       <= '0;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dot_ff       <= dot_in;
         ea_ff        <= ea_in;
         eb_ff        <= eb_in;
         l1_ff        <= l1_in;
         cnt_ff       <= cnt_in;
         zero_ff      <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == sar_pkg::ST_IDLE && req_tvalid) begin
         a_ff    <= req_tdata[SW-1:0] & SampleMask;
         b_ff    <= req_tdata[2*SW-1:SW] & SampleMask;
         last_ff <= req_tlast;
      end
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      ra_ff        <= ra_in;
      prod_ff      <= prod_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      xt_ff        <= xt_in;
      z_ff         <= z_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_l1_ff    <= rsp_l1_in;
      rsp_zero_ff  <= rsp_zero_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_l1_ff, rsp_angle_ff};
   assign rsp_tuser  = rsp_zero_ff;

endmodule
`default_nettype wire
